[design/hbsc_pkg.sv]
// ----------------------------------------------------------------------------
// hbsc_pkg
// shared types and constants for the hdlc bit stuffing / crc framer
// ----------------------------------------------------------------------------
package hbsc_pkg;

  // frame length limit in line bits
  localparam int unsigned FrameBits = 4096;
  // width of the frame bit counter, holds 0..FrameBits
  localparam int unsigned CntW      = 13;

  localparam logic [15:0] CrcPoly  = 16'h8408;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [2:0]  StuffRun = 3'd5;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_FLAG   = 2'd2,
    ACT_FOOTER = 2'd3
  } action_e;

  typedef struct packed {
    logic [15:0]     crc;
    logic [2:0]      ones;
    logic [CntW-1:0] bit_count;
    logic            full;
  } state_t;

  localparam state_t ResetState = '{
    crc:       CrcInit,
    ones:      3'd0,
    bit_count: '0,
    full:      1'b0
  };

endpackage

[design/hbsc_if.sv]
// ----------------------------------------------------------------------------
// hbsc_in_if / hbsc_out_if
// valid/ready channels for framer commands and emitted line words
// ----------------------------------------------------------------------------
interface hbsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface hbsc_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  line_bits;
  logic [3:0]  line_bit_count;
  logic [12:0] frame_length;
  logic        overflow;
  logic        last;

  modport source (output valid, line_bits, line_bit_count, frame_length, overflow, last,
                  input ready);
  modport sink   (input valid, line_bits, line_bit_count, frame_length, overflow, last,
                  output ready);
endinterface

[design/hbsc_byte_unit.sv]
// ----------------------------------------------------------------------------
// hbsc_byte_unit
// one byte of crc update, bit stuffing and frame length limiting
// ----------------------------------------------------------------------------
module hbsc_byte_unit (
  input  hbsc_pkg::state_t  st_i,
  input  hbsc_pkg::action_e act_i,
  input  logic [7:0]        byte_i,
  output hbsc_pkg::state_t  st_o,
  output logic [9:0]        bits_o,
  output logic [3:0]        count_o
);

  always_comb begin
    logic [15:0]               crc;
    logic [15:0]               c;
    logic [2:0]                run;
    logic [3:0]                pos;
    logic [9:0]                raw;
    logic [9:0]                mask;
    logic [hbsc_pkg::CntW-1:0] room;
    logic [3:0]                emit;
    logic                      drop;
    logic                      b;

    crc  = st_i.crc;
    run  = st_i.ones;
    pos  = 4'd0;
    raw  = '0;
    c    = '0;
    b    = 1'b0;

    unique case (act_i)
      hbsc_pkg::ACT_START: begin
        pos = 4'd0;
      end
      hbsc_pkg::ACT_DATA: begin
        for (int i = 0; i < 8; i++) begin
          b   = byte_i[i];
          c   = crc ^ {15'd0, b};
          crc = c[0] ? ((c >> 1) ^ hbsc_pkg::CrcPoly) : (c >> 1);
          raw[pos] = b;
          pos = pos + 4'd1;
          if (b) begin
            run = run + 3'd1;
            if (run >= hbsc_pkg::StuffRun) begin
              // stuffed zero, raw is already clear there
              pos = pos + 4'd1;
              run = 3'd0;
            end
          end else begin
            run = 3'd0;
          end
        end
      end
      // footer is split into data and flag steps upstream
      hbsc_pkg::ACT_FLAG, hbsc_pkg::ACT_FOOTER: begin
        raw = {2'b00, hbsc_pkg::FlagByte};
        pos = 4'd8;
      end
    endcase

    // keep only the bits that still fit in the frame
    room = hbsc_pkg::CntW'(hbsc_pkg::FrameBits) - st_i.bit_count;
    drop = room < hbsc_pkg::CntW'(pos);
    emit = drop ? room[3:0] : pos;
    for (int i = 0; i < 10; i++) begin
      mask[i] = 4'(i) < emit;
    end

    if (act_i == hbsc_pkg::ACT_START) begin
      st_o    = hbsc_pkg::ResetState;
      bits_o  = '0;
      count_o = 4'd0;
    end else begin
      st_o.crc       = crc;
      st_o.ones      = run;
      st_o.bit_count = st_i.bit_count + hbsc_pkg::CntW'(emit);
      st_o.full      = st_i.full | drop;
      bits_o         = raw & mask;
      count_o        = emit;
    end
  end

endmodule

[design/hdlc_bit_stuff_crc_framer_core.sv]
// ----------------------------------------------------------------------------
// hdlc_bit_stuff_crc_framer_core
// hdlc / ax.25 transmit framer: bit stuffing, crc-16 (0x8408), flags
// ----------------------------------------------------------------------------
// channel   dir  payload                                              role
// item_i    in   action, data_byte                                    framer commands
// result_o  out  line_bits, line_bit_count, frame_length, overflow,   emitted line words
//                last
//
// one command is taken per cycle while result_o does not stall; start, data
// and flag give one word each, the footer gives three words and holds the
// command register through its low, high and flag phases. commands pass the
// command register, then the byte unit into the result register, which frees
// as it is taken, so a stalled result_o blocks only once both registers are full.
// reset (rst_ni low, async) gives crc 0xffff, empty ones run and length zero.
// ----------------------------------------------------------------------------
module hdlc_bit_stuff_crc_framer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbsc_in_if.sink    item_i,
  hbsc_out_if.source result_o
);

  // footer sequencing: crc low byte, crc high byte, closing flag
  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_FLAG = 2'd2
  } phase_e;

  // command register
  logic              item_vld_q;
  hbsc_pkg::action_e item_act_q;
  logic [7:0]        item_byte_q;
  phase_e            phase_q;

  // framer state
  hbsc_pkg::state_t  st_q, st_d;

  // result register
  logic              res_vld_q;
  logic [9:0]        res_bits_q;
  logic [3:0]        res_count_q;
  logic [12:0]       res_len_q;
  logic              res_ovf_q;
  logic              res_last_q;

  // byte unit hookup
  hbsc_pkg::action_e unit_act;
  logic [7:0]        unit_byte;
  logic [9:0]        unit_bits;
  logic [3:0]        unit_count;

  logic is_footer;
  logic step_last;
  logic advance;
  logic item_done;
  logic accept;

  assign is_footer = item_act_q == hbsc_pkg::ACT_FOOTER;
  assign step_last = !is_footer || (phase_q == PH_FLAG);

  // one word is produced whenever a command is held and the result register is free or draining
  assign advance   = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_done = advance && step_last;
  assign item_i.ready = !item_vld_q || item_done;
  assign accept    = item_i.valid && item_i.ready;

  // footer: data steps for both crc bytes, then a flag step
  always_comb begin
    unit_act  = item_act_q;
    unit_byte = item_byte_q;
    if (is_footer) begin
      unit_act = (phase_q == PH_FLAG) ? hbsc_pkg::ACT_FLAG : hbsc_pkg::ACT_DATA;
      // low byte comes straight from the crc held before the footer
      if (phase_q == PH_LOW) begin
        unit_byte = ~st_q.crc[7:0];
      end
    end
  end

  hbsc_byte_unit u_byte (
    .st_i    (st_q),
    .act_i   (unit_act),
    .byte_i  (unit_byte),
    .st_o    (st_d),
    .bits_o  (unit_bits),
    .count_o (unit_count)
  );

  // control: valid bits, footer phase, framer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      phase_q    <= PH_LOW;
      res_vld_q  <= 1'b0;
      st_q       <= hbsc_pkg::ResetState;
    end else begin
      if (accept) begin
        item_vld_q <= 1'b1;
        phase_q    <= PH_LOW;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end else if (advance && is_footer) begin
        phase_q <= (phase_q == PH_LOW) ? PH_HIGH : PH_FLAG;
      end

      if (advance) begin
        res_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (result_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_act_q  <= hbsc_pkg::action_e'(item_i.action);
      item_byte_q <= item_i.data_byte;
    end else if (advance && is_footer && (phase_q == PH_LOW)) begin
      // park the high crc byte as it stood before the footer began
      item_byte_q <= ~st_q.crc[15:8];
    end

    if (advance) begin
      res_bits_q  <= unit_bits;
      res_count_q <= unit_count;
      res_len_q   <= 13'(st_d.bit_count);
      res_ovf_q   <= st_d.full;
      res_last_q  <= step_last;
    end
  end

  assign result_o.valid          = res_vld_q;
  assign result_o.line_bits      = res_bits_q;
  assign result_o.line_bit_count = res_count_q;
  assign result_o.frame_length   = res_len_q;
  assign result_o.overflow       = res_ovf_q;
  assign result_o.last           = res_last_q;

`ifndef SYNTHESIS
  // no new command may slip in before a footer has finished its three words
  a_footer_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && is_footer && (phase_q != PH_FLAG)) |-> !item_i.ready)
    else $error("command accepted in the middle of a footer");

  // a start word reports an empty, clean frame
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (item_act_q == hbsc_pkg::ACT_START)) |=>
      (res_vld_q && (res_len_q == 13'd0) && !res_ovf_q && (res_count_q == 4'd0)))
    else $error("start frame did not clear the frame state");

  // the length counter never runs past the frame limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.bit_count <= hbsc_pkg::CntW'(hbsc_pkg::FrameBits))
    else $error("frame bit count beyond limit");

  // a word is shown with a bit count that fits the line field
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_count_q <= 4'd10))
    else $error("line bit count out of range");
`endif

endmodule

[tb/tb_hdlc_bit_stuff_crc_framer_core.sv]
// ----------------------------------------------------------------------------
// tb_hdlc_bit_stuff_crc_framer_core
// self-checking bench for the hdlc framer: commands go in on item_i, every
// line word on result_o is compared field by field against an in-bench
// model of the stuffing, crc-16 and frame length logic
// ----------------------------------------------------------------------------
module tb_hdlc_bit_stuff_crc_framer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // run length guard and receiver hold-off length
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 150;

  // one expected line word
  typedef struct packed {
    logic [9:0]                bits;
    logic [3:0]                cnt;
    logic [hbsc_pkg::CntW-1:0] len;
    logic                      ovf;
    logic                      last;
  } line_word_t;

  logic clk = 1'b0;
  logic rst_ni;

  hbsc_in_if  item_if ();
  hbsc_out_if word_if ();

  hdlc_bit_stuff_crc_framer_core dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (word_if)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // framer model state, advanced once per accepted command
  // ---------------------------------------------------------------------------
  logic [15:0]               tx_crc  = hbsc_pkg::CrcInit;
  logic [2:0]                tx_ones = '0;
  logic [hbsc_pkg::CntW-1:0] tx_len  = '0;
  logic                      tx_full = 1'b0;

  // line words still owed by the framer, oldest first
  line_word_t pending_words[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;

  // sender pacing
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  // receiver pacing: a token bump asks the pacing process for a long hold-off
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  logic [8:0]  rx_tick    = '0;

  // put one bit on the line unless the frame is already full
  function automatic void put_bit(inout logic [9:0] lb, inout int unsigned nb, input logic b);
    if (tx_len >= hbsc_pkg::FrameBits) begin
      tx_full = 1'b1;
      return;
    end
    if (nb < 10) lb[nb] = b;
    nb++;
    tx_len++;
  endfunction

  // reflected crc-16, one bit
  function automatic void crc_shift(input logic b);
    logic fb;
    fb     = tx_crc[0] ^ b;
    tx_crc = tx_crc >> 1;
    if (fb) tx_crc = tx_crc ^ hbsc_pkg::CrcPoly;
  endfunction

  // data byte lsb first, crc update and zero insertion after five ones
  function automatic void stuff_byte(inout logic [9:0] lb, inout int unsigned nb,
                                     input logic [7:0] d);
    for (int i = 0; i < 8; i++) begin
      crc_shift(d[i]);
      put_bit(lb, nb, d[i]);
      if (d[i]) begin
        tx_ones++;
        if (tx_ones >= hbsc_pkg::StuffRun) begin
          put_bit(lb, nb, 1'b0);
          tx_ones = '0;
        end
      end else begin
        tx_ones = '0;
      end
    end
  endfunction

  // flag goes out raw: no crc, no stuffing, ones run untouched
  function automatic void flag_bits(inout logic [9:0] lb, inout int unsigned nb);
    for (int i = 0; i < 8; i++) put_bit(lb, nb, hbsc_pkg::FlagByte[i]);
  endfunction

  function automatic void owe_word(input logic [9:0] lb, input int unsigned nb, input logic lst);
    line_word_t w;
    w.bits = lb;
    w.cnt  = nb[3:0];
    w.len  = tx_len;
    w.ovf  = tx_full;
    w.last = lst;
    pending_words.push_back(w);
  endfunction

  // work out the words one accepted command produces
  function automatic void frame_cmd(input hbsc_pkg::action_e act, input logic [7:0] d);
    logic [9:0]  lb;
    int unsigned nb;
    logic [15:0] fcs;
    lb = '0;
    nb = 0;
    case (act)
      hbsc_pkg::ACT_START: begin
        tx_crc  = hbsc_pkg::CrcInit;
        tx_ones = '0;
        tx_len  = '0;
        tx_full = 1'b0;
        owe_word(lb, nb, 1'b1);
      end
      hbsc_pkg::ACT_DATA: begin
        stuff_byte(lb, nb, d);
        owe_word(lb, nb, 1'b1);
      end
      hbsc_pkg::ACT_FLAG: begin
        flag_bits(lb, nb);
        owe_word(lb, nb, 1'b1);
      end
      default: begin
        // both fcs bytes come from the crc as it stood before the footer
        fcs = ~tx_crc;
        stuff_byte(lb, nb, fcs[7:0]);
        owe_word(lb, nb, 1'b0);
        lb = '0;
        nb = 0;
        stuff_byte(lb, nb, fcs[15:8]);
        owe_word(lb, nb, 1'b0);
        lb = '0;
        nb = 0;
        flag_bits(lb, nb);
        owe_word(lb, nb, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offer one command, wait for the handshake, then maybe take a gap
  // valid stays high into the next command unless a gap is taken
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input hbsc_pkg::action_e act, input logic [7:0] d);
    item_if.valid     <= 1'b1;
    item_if.action    <= act;
    item_if.data_byte <= d;
    do @(posedge clk); while (!item_if.ready);
    frame_cmd(act, d);
    if (gaps_on) begin
      if (burst_left == 0) begin
        item_if.valid <= 1'b0;
        burst_left = $urandom_range(0, 12);
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop offering and let every owed word come out
  task automatic wait_all_words();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  function automatic void cmp_field(input string f, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h) got %0d (0x%0h)",
               $time, f, want, want, got, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // receiver pacing: rotating stall patterns, with stall-free stretches, plus
  // a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= HoldCycles;
      word_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      word_if.ready <= 1'b0;
    end else begin
      case (rx_tick[8:6])
        3'd0, 3'd1, 3'd4: word_if.ready <= 1'b1;
        3'd2:             word_if.ready <= ($urandom_range(0, 3) != 0);
        3'd3:             word_if.ready <= (rx_tick[1:0] == 2'd0);
        3'd5:             word_if.ready <= 1'($urandom_range(0, 1));
        default:          word_if.ready <= (rx_tick[2:0] != 3'd5);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // word checker: every taken word against the oldest owed word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_check
    line_word_t want;
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none got bits 0x%0h cnt %0d len %0d",
                 $time, word_if.line_bits, word_if.line_bit_count, word_if.frame_length);
        errors++;
      end else begin
        want = pending_words.pop_front();
        cmp_field("line_bits", want.bits, word_if.line_bits);
        cmp_field("line_bit_count", want.cnt, word_if.line_bit_count);
        cmp_field("frame_length", want.len, word_if.frame_length);
        cmp_field("overflow", want.ovf, word_if.overflow);
        cmp_field("last", want.last, word_if.last);
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** hdlc_bit_stuff_crc_framer_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // commands straight out of reset, no start frame yet
  task automatic test_reset_state();
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);
    push_cmd(hbsc_pkg::ACT_DATA, 8'h00);
    push_cmd(hbsc_pkg::ACT_FLAG, 8'hA5);
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'h5A);
  endtask

  // field extremes, stuffing corners, every action
  task automatic test_directed_cases();
    push_cmd(hbsc_pkg::ACT_START, 8'hFF);      // data byte ignored on start
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'h00);     // footer of an empty frame
    push_cmd(hbsc_pkg::ACT_START, 8'h00);
    push_cmd(hbsc_pkg::ACT_FLAG, 8'hFF);
    push_cmd(hbsc_pkg::ACT_DATA, 8'h00);
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);       // five ones then a stuffed zero
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);       // ones run carried over the byte edge
    push_cmd(hbsc_pkg::ACT_DATA, 8'h1F);       // exactly five ones
    push_cmd(hbsc_pkg::ACT_DATA, 8'hF8);       // five ones, stuffed zero at the byte end
    push_cmd(hbsc_pkg::ACT_FLAG, 8'h00);       // flag does not clear the run
    push_cmd(hbsc_pkg::ACT_DATA, 8'h01);       // a lone one, no stuffing
    push_cmd(hbsc_pkg::ACT_DATA, 8'h7E);
    push_cmd(hbsc_pkg::ACT_DATA, 8'h80);
    push_cmd(hbsc_pkg::ACT_DATA, 8'hAA);
    push_cmd(hbsc_pkg::ACT_DATA, 8'h55);
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'hC3);
    push_cmd(hbsc_pkg::ACT_START, 8'h3C);
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'hFF);
    push_cmd(hbsc_pkg::ACT_FLAG, 8'h7E);
  endtask

  // fill a frame up to the length limit and run over it; all-ones bytes
  // stuff the most and so reach the limit in the fewest commands
  task automatic test_frame_overflow();
    push_cmd(hbsc_pkg::ACT_START, 8'h00);
    while (tx_len < hbsc_pkg::FrameBits - 40) push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);
    repeat (3) push_cmd(hbsc_pkg::ACT_DATA, 8'($urandom));
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'h00);     // straddles the limit
    push_cmd(hbsc_pkg::ACT_FLAG, 8'h00);
    push_cmd(hbsc_pkg::ACT_DATA, 8'hFF);
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'h00);
    push_cmd(hbsc_pkg::ACT_START, 8'h00);      // start clears the overflow
    push_cmd(hbsc_pkg::ACT_DATA, 8'h55);
    push_cmd(hbsc_pkg::ACT_FOOTER, 8'h00);
  endtask

  // receiver holds off while commands keep coming, so the input stalls
  task automatic test_output_stall();
    gaps_on = 1'b0;
    hold_token <= hold_token + 1;
    push_cmd(hbsc_pkg::ACT_START, 8'h00);
    for (int i = 0; i < 24; i++) begin
      if (i % 6 == 5) push_cmd(hbsc_pkg::ACT_FOOTER, 8'($urandom));
      else push_cmd(hbsc_pkg::ACT_DATA, 8'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  // mostly well-formed frames with random content, some noise and broken
  // frames; the sender drains once halfway
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned nbytes;
    int unsigned pick;
    bit          drained;
    logic [7:0]  d;
    sent    = 0;
    drained = 1'b0;
    while (sent < 100) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        push_cmd(hbsc_pkg::action_e'($urandom_range(0, 3)), 8'($urandom));
        sent++;
      end else begin
        push_cmd(hbsc_pkg::ACT_START, 8'($urandom));
        push_cmd(hbsc_pkg::ACT_FLAG, 8'($urandom));
        nbytes = (pick < 20) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        sent += 2 + nbytes;
        for (int i = 0; i < nbytes; i++) begin
          d = 8'($urandom);
          case ($urandom_range(0, 4))
            0: d = 8'hFF;
            1: d = 8'h00;
            2: d = d | 8'h3E;        // long runs of ones
            default: ;
          endcase
          if ($urandom_range(0, 9) == 0) begin
            push_cmd(hbsc_pkg::ACT_FLAG, 8'($urandom));
            sent++;
          end
          push_cmd(hbsc_pkg::ACT_DATA, d);
        end
        // now and then a frame is left without its footer
        if (pick % 7 != 0) begin
          push_cmd(hbsc_pkg::ACT_FOOTER, 8'($urandom));
          sent++;
        end
      end
      if (!drained && sent >= 50) begin
        wait_all_words();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    item_if.valid     = 1'b0;
    item_if.action    = hbsc_pkg::ACT_START;
    item_if.data_byte = '0;
    word_if.ready     = 1'b0;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_frame_overflow();
    test_output_stall();
    test_random_frames();

    wait_all_words();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** hdlc_bit_stuff_crc_framer_core: PASSED **");
    end else begin
      $display("** hdlc_bit_stuff_crc_framer_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/hbsc_pkg.sv
design/hbsc_if.sv
design/hbsc_byte_unit.sv
design/hdlc_bit_stuff_crc_framer_core.sv
tb/tb_hdlc_bit_stuff_crc_framer_core.sv
